// File: hdl/rc_pkg.sv
// Types, codes and the control program of the radix converter.
`default_nettype none

package rc_pkg;

    localparam int DIGIT_WIDTH = 6;
    localparam int CHAR_WIDTH  = 7;
    localparam int STEP_WIDTH  = 3;

    localparam logic [DIGIT_WIDTH-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_WIDTH-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT    = 6'd36;

    localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
    localparam logic [7:0] CHAR_A    = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_Z    = 8'h7a;  // 'z'

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_IN_RADIX  = 1'b0,
        CFG_OUT_RADIX = 1'b1
    } cfg_index_t;

    typedef logic [STEP_WIDTH-1:0] step_t;

    localparam step_t STEP_ACCEPT   = 3'd0;
    localparam step_t STEP_INIT     = 3'd1;
    localparam step_t STEP_DIV      = 3'd2;
    localparam step_t STEP_STORE    = 3'd3;
    localparam step_t STEP_READ     = 3'd4;
    localparam step_t STEP_EMIT     = 3'd5;
    localparam step_t STEP_CLEAR    = 3'd6;
    localparam step_t STEP_EMIT_ERR = 3'd7;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_INIT,
        OP_DIV,
        OP_STORE,
        OP_READ,
        OP_EMIT,
        OP_CLEAR,
        OP_EMIT_ERR
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST,
        C_ERR,
        C_BIT_MORE,
        C_VALUE_NZ,
        C_COUNT_NZ
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Control store: when the condition holds the sequencer jumps to target,
    // otherwise it falls through to the next step.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        unique case (step)
            STEP_ACCEPT:   w = '{OP_ACCEPT,   C_NOT_LAST, STEP_ACCEPT};
            STEP_INIT:     w = '{OP_INIT,     C_ERR,      STEP_EMIT_ERR};
            STEP_DIV:      w = '{OP_DIV,      C_BIT_MORE, STEP_DIV};
            STEP_STORE:    w = '{OP_STORE,    C_VALUE_NZ, STEP_DIV};
            STEP_READ:     w = '{OP_READ,     C_NEVER,    STEP_READ};
            STEP_EMIT:     w = '{OP_EMIT,     C_COUNT_NZ, STEP_READ};
            STEP_CLEAR:    w = '{OP_CLEAR,    C_ALWAYS,   STEP_ACCEPT};
            STEP_EMIT_ERR: w = '{OP_EMIT_ERR, C_ALWAYS,   STEP_CLEAR};
            default:       w = '{OP_CLEAR,    C_ALWAYS,   STEP_ACCEPT};
        endcase
        return w;
    endfunction

    function automatic logic [DIGIT_WIDTH-1:0] clamp_radix(input logic [DIGIT_WIDTH-1:0] r);
        logic [DIGIT_WIDTH-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Digit value of a character; NO_DIGIT when it is not a digit at all.
    function automatic logic [DIGIT_WIDTH-1:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_A && c <= CHAR_Z) begin
            v = c - CHAR_A + 8'd10;
        end else begin
            v = {2'b00, NO_DIGIT};
        end
        return v[DIGIT_WIDTH-1:0];
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] value_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_A + {2'b00, d} - 8'd10;
        end
        return c[CHAR_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/rc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 63
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/radix_converter.sv
// Radix converter: base 2..36 ASCII digits in, base 2..36 ASCII digits out.
// Input digits take one cycle each. After the last digit, each output digit
// is worked out in the bit-serial divider and stored; then each digit is
// read back and sent, and an error result skips the divider and the store.
// No new digit is taken until the whole number has been sent.
// aresetn (synchronous, active low) sets both radixes to 10 and clears the value.
`default_nettype none

module radix_converter #(
    parameter int VALUE_WIDTH = 63
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Configuration write port.
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data,
    // Input digits.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] digit_char
    input  wire logic       s_tlast,   // last_digit
    // Output digits.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic            m_tlast,   // last_out
    output logic      [1:0] m_tuser    // [1:0] status
);

    localparam int DW = rc_pkg::DIGIT_WIDTH;
    localparam int PW = VALUE_WIDTH + DW + 1;
    localparam int DEPTH = VALUE_WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int BW = $clog2(VALUE_WIDTH);

    rc_pkg::step_t   step_reg, step_next;
    rc_pkg::uword_t  uw;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    rc_pkg::status_t err_reg, err_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [BW-1:0]   bit_reg, bit_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [DW-1:0]   in_radix_reg, in_radix_next;
    logic [DW-1:0]   out_radix_reg, out_radix_next;
    logic            m_valid_reg, m_valid_next;
    logic [rc_pkg::CHAR_WIDTH-1:0] m_char_reg, m_char_next;
    logic            m_last_reg, m_last_next;
    rc_pkg::status_t m_status_reg, m_status_next;

    logic [DW-1:0]   rin, rout, digit;
    logic [PW-1:0]   prod;
    logic            overflow;
    logic            in_xfer, slot_free, hold, cond_ok;
    logic [DW:0]     shifted;
    logic [CW-1:0]   count_dec;
    logic [DW-1:0]   ram_rdata;
    logic            ram_we, ram_re;

    assign uw       = rc_pkg::ucode(step_reg);
    assign rin      = rc_pkg::clamp_radix(in_radix_reg);
    assign rout     = rc_pkg::clamp_radix(out_radix_reg);
    assign digit    = rc_pkg::char_value(s_tdata);
    assign prod     = PW'(acc_reg) * PW'(rin) + PW'(digit);
    assign overflow = |prod[PW-1:VALUE_WIDTH];

    assign s_tready  = (uw.op == rc_pkg::OP_ACCEPT);
    assign in_xfer   = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    // One restoring division step: bring in the next dividend bit.
    assign shifted   = {rem_reg, acc_reg[VALUE_WIDTH-1]};
    assign count_dec = count_reg - CW'(1);

    assign ram_we = (uw.op == rc_pkg::OP_STORE);
    assign ram_re = (uw.op == rc_pkg::OP_READ);

    rc_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_digit_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(rem_reg),
        .re   (ram_re),
        .raddr(count_dec[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        unique case (uw.cond)
            rc_pkg::C_NEVER:    cond_ok = 1'b0;
            rc_pkg::C_ALWAYS:   cond_ok = 1'b1;
            rc_pkg::C_NOT_LAST: cond_ok = !s_tlast;
            rc_pkg::C_ERR:      cond_ok = (err_reg != rc_pkg::ST_OK);
            rc_pkg::C_BIT_MORE: cond_ok = (bit_reg != BW'(VALUE_WIDTH - 1));
            rc_pkg::C_VALUE_NZ: cond_ok = (acc_reg != '0);
            rc_pkg::C_COUNT_NZ: cond_ok = (count_reg != '0);
            default:            cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        step_next      = step_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        count_next     = count_reg;
        in_radix_next  = in_radix_reg;
        out_radix_next = out_radix_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;
        hold           = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                2'(rc_pkg::CFG_IN_RADIX):  in_radix_next  = cfg_data;
                2'(rc_pkg::CFG_OUT_RADIX): out_radix_next = cfg_data;
                default: ;
            endcase
        end

        unique case (uw.op)
            rc_pkg::OP_ACCEPT: begin
                hold = !in_xfer;
                if (in_xfer && err_reg == rc_pkg::ST_OK) begin
                    if (digit >= rin) begin
                        err_next = rc_pkg::ST_INVALID;
                    end else if (overflow) begin
                        err_next = rc_pkg::ST_OVERFLOW;
                    end else begin
                        acc_next = prod[VALUE_WIDTH-1:0];
                    end
                end
            end
            rc_pkg::OP_INIT: begin
                rem_next   = '0;
                bit_next   = '0;
                count_next = '0;
            end
            rc_pkg::OP_DIV: begin
                bit_next = bit_reg + BW'(1);
                if (shifted >= {1'b0, rout}) begin
                    rem_next = DW'(shifted - {1'b0, rout});
                    acc_next = {acc_reg[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = shifted[DW-1:0];
                    acc_next = {acc_reg[VALUE_WIDTH-2:0], 1'b0};
                end
            end
            rc_pkg::OP_STORE: begin
                count_next = count_reg + CW'(1);
                rem_next   = '0;
                bit_next   = '0;
            end
            rc_pkg::OP_READ: begin
                count_next = count_dec;
            end
            rc_pkg::OP_EMIT: begin
                hold = !slot_free;
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_char_next   = rc_pkg::value_char(ram_rdata);
                    m_last_next   = (count_reg == '0);
                    m_status_next = rc_pkg::ST_OK;
                end
            end
            rc_pkg::OP_EMIT_ERR: begin
                hold = !slot_free;
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_char_next   = '0;
                    m_last_next   = 1'b1;
                    m_status_next = err_reg;
                end
            end
            rc_pkg::OP_CLEAR: begin
                acc_next   = '0;
                err_next   = rc_pkg::ST_OK;
                count_next = '0;
            end
            default: ;
        endcase

        if (!hold) begin
            step_next = cond_ok ? uw.target : rc_pkg::step_t'(step_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= rc_pkg::STEP_ACCEPT;
            acc_reg       <= '0;
            err_reg       <= rc_pkg::ST_OK;
            count_reg     <= '0;
            in_radix_reg  <= rc_pkg::RADIX_RESET;
            out_radix_reg <= rc_pkg::RADIX_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            in_radix_reg  <= in_radix_next;
            out_radix_reg <= out_radix_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath and output payload need no reset.
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

    // The digit store never overfills: a full-width value has at most
    // VALUE_WIDTH digits.
    a_store_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == rc_pkg::OP_STORE) |-> (count_reg < CW'(VALUE_WIDTH)))
        else $error("digit store written beyond its depth");

    // The partial remainder stays below the divisor throughout a division.
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == rc_pkg::OP_DIV) |-> (rem_reg < rout))
        else $error("partial remainder not below output radix");

    // An error result always carries a zero character and ends the number.
    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != 2'(rc_pkg::ST_OK)) |-> (m_tdata == '0 && m_tlast))
        else $error("malformed error result");

    // A digit that is not the last one leaves the sequencer waiting for more.
    a_stay_on_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_tlast) |=> (step_reg == rc_pkg::STEP_ACCEPT))
        else $error("sequencer left digit intake early");

endmodule

`default_nettype wire

// File: verif/tb_radix_converter.sv
// Self-checking testbench for the radix converter: digit streams in, converted digits out.
`default_nettype none

module tb_radix_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned VALUE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int              STALL_LIMIT = 20000;
    localparam int              RANDOM_ITEMS = 300;
    localparam int              NUM_PHASES  = 6;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [rc_pkg::CHAR_WIDTH-1:0] out_char;
        logic                          last_out;
        rc_pkg::status_t               status;
    } out_digit_t;

    // Keeps its own copy of the radixes and of the running value, and queues the
    // digits that each completed number must produce.
    class radix_scoreboard;
        int unsigned     in_radix  = 10;
        int unsigned     out_radix = 10;
        longint unsigned value     = 0;
        rc_pkg::status_t err       = rc_pkg::ST_OK;
        out_digit_t      expected_digits[$];
        int              failures  = 0;

        static function int unsigned clamp(logic [rc_pkg::DIGIT_WIDTH-1:0] r);
            if (r < 2) return 2;
            if (r > 36) return 36;
            return r;
        endfunction

        static function logic [7:0] digit_char(int unsigned d);
            return (d < 10) ? rc_pkg::CHAR_ZERO + 8'(d) : rc_pkg::CHAR_A + 8'(d - 10);
        endfunction

        static function int unsigned char_digit(logic [7:0] c);
            if (c >= rc_pkg::CHAR_ZERO && c <= rc_pkg::CHAR_NINE) return c - rc_pkg::CHAR_ZERO;
            if (c >= rc_pkg::CHAR_A && c <= rc_pkg::CHAR_Z) return c - rc_pkg::CHAR_A + 10;
            return 36;
        endfunction

        // Digits of v in radix r, most significant first.
        static function char_q_t digits_of(longint unsigned v, int unsigned r);
            char_q_t q;
            do begin
                q.push_front(digit_char(32'(v % r)));
                v = v / r;
            end while (v != 0);
            return q;
        endfunction

        function void set_radix(rc_pkg::cfg_index_t idx, logic [rc_pkg::DIGIT_WIDTH-1:0] v);
            if (idx == rc_pkg::CFG_IN_RADIX) begin
                in_radix = clamp(v);
            end else begin
                out_radix = clamp(v);
            end
        endfunction

        function void note_digit(logic [7:0] c, bit lst);
            int unsigned d;
            char_q_t     q;
            out_digit_t  e;
            d = char_digit(c);
            // Only the first error of a number counts; later digits are ignored.
            if (err == rc_pkg::ST_OK) begin
                if (d >= in_radix) begin
                    err = rc_pkg::ST_INVALID;
                end else if (value > (VALUE_MAX - d) / in_radix) begin
                    err = rc_pkg::ST_OVERFLOW;
                end else begin
                    value = value * in_radix + d;
                end
            end
            if (!lst) return;
            if (err != rc_pkg::ST_OK) begin
                e.out_char = '0;
                e.last_out = 1'b1;
                e.status   = err;
                expected_digits.push_back(e);
            end else begin
                q = digits_of(value, out_radix);
                foreach (q[i]) begin
                    e.out_char = q[i][rc_pkg::CHAR_WIDTH-1:0];
                    e.last_out = (i == q.size() - 1);
                    e.status   = rc_pkg::ST_OK;
                    expected_digits.push_back(e);
                end
            end
            value = 0;
            err   = rc_pkg::ST_OK;
        endfunction

        function void check_output(logic [7:0] tdata, logic tlast, logic [1:0] tuser);
            out_digit_t e;
            if (expected_digits.size() == 0) begin
                $error("unexpected output transfer: out_char %0h last_out %0b status %0d",
                       tdata, tlast, tuser);
                failures++;
                return;
            end
            e = expected_digits.pop_front();
            if (tdata !== {1'b0, e.out_char}) begin
                $error("out_char: expected %0h, got %0h", {1'b0, e.out_char}, tdata);
                failures++;
            end
            if (tlast !== e.last_out) begin
                $error("last_out: expected %0b, got %0b", e.last_out, tlast);
                failures++;
            end
            if (tuser !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, tuser);
                failures++;
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [5:0] cfg_data  = '0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    radix_scoreboard sb = new();
    int items_sent   = 0;
    int stall_cycles = 0;

    radix_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Result side: check each transfer, then pick the next ready level.
    always @(posedge aclk) begin
        int idle_pct;
        idle_pct = (items_sent < 100) ? 51 : (items_sent < 200) ? 32 : 0;
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_output(m_tdata, m_tlast, m_tuser);
        end
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog on cycles without any transfer or register write.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_digit(input logic [7:0] c, input bit lst);
        int gap = 0;
        int idle_pct;
        idle_pct = (items_sent < 100) ? 32 : (items_sent < 200) ? 51 : 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_digit(c, lst);
        items_sent++;
    endtask

    task automatic send_number(input char_q_t q);
        foreach (q[i]) push_digit(q[i], i == q.size() - 1);
    endtask

    // Waits until every expected digit is out and the converter has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_radixes(input logic [5:0] rin, input logic [5:0] rout);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= 2'(rc_pkg::CFG_IN_RADIX);
        cfg_data  <= rin;
        @(posedge aclk);
        sb.set_radix(rc_pkg::CFG_IN_RADIX, rin);
        cfg_index <= 2'(rc_pkg::CFG_OUT_RADIX);
        cfg_data  <= rout;
        @(posedge aclk);
        sb.set_radix(rc_pkg::CFG_OUT_RADIX, rout);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_number();
        char_q_t     q;
        int unsigned r;
        int unsigned longest;
        int unsigned len;
        int unsigned kind;
        int unsigned pos;
        r       = sb.in_radix;
        q       = radix_scoreboard::digits_of(VALUE_MAX, r);
        longest = q.size();
        q.delete();
        kind    = $urandom_range(99);
        if (kind < 85) begin
            // Well-formed digits, sometimes long enough to reach the overflow limit.
            len = $urandom_range(99);
            if (len < 50) len = $urandom_range(6, 1);
            else if (len < 85) len = $urandom_range(longest - 1, 1);
            else len = $urandom_range(longest + 1, longest);
            repeat (len) q.push_back(radix_scoreboard::digit_char($urandom_range(r - 1)));
            if (kind >= 70) begin
                // One bad character somewhere in an otherwise valid number.
                pos = $urandom_range(len - 1);
                case ($urandom_range(2))
                    0: q[pos] = (r < 36) ? radix_scoreboard::digit_char($urandom_range(35, r))
                                         : rc_pkg::CHAR_Z + 8'd1;
                    1: q[pos] = rc_pkg::CHAR_A - 8'h20 + 8'($urandom_range(25));
                    default: q[pos] = 8'($urandom_range(255));
                endcase
            end
        end else if (kind < 95) begin
            len = $urandom_range(4, 1);
            repeat (len) q.push_back(8'($urandom_range(255)));
        end else begin
            // Right at the top of the value range; an extra digit always overflows.
            q = radix_scoreboard::digits_of(VALUE_MAX - $urandom_range(2), r);
            if ($urandom_range(1)) q.push_back(radix_scoreboard::digit_char($urandom_range(r - 1)));
        end
        send_number(q);
    endtask

    initial begin
        logic [5:0] in_list[NUM_PHASES];
        logic [5:0] out_list[NUM_PHASES];
        char_q_t    q;
        int         goal;

        in_list  = '{6'd2, 6'd0, 6'd63, 6'd16, 6'd36, 6'($urandom_range(36, 2))};
        out_list = '{6'd36, 6'd1, 6'd37, 6'd8, 6'd2, 6'($urandom_range(63))};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset radixes: zero, and an upper case letter ahead of a valid digit.
        q = '{rc_pkg::CHAR_ZERO};
        send_number(q);
        q = '{rc_pkg::CHAR_A - 8'h20, rc_pkg::CHAR_ZERO + 8'd7};
        send_number(q);

        // Largest value in base 36 gives the longest binary result; one more overflows.
        set_radixes(6'd36, 6'd2);
        q = radix_scoreboard::digits_of(VALUE_MAX, 36);
        send_number(q);
        q[q.size() - 1] = q[q.size() - 1] + 8'd1;
        send_number(q);

        goal = items_sent;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_radixes(in_list[p], out_list[p]);
            goal = goal + RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < goal) random_number();
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
